// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the engine file to check the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ALLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ALLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/alle_pkg.sv =====
package alle_pkg;

  localparam int CAPACITY = 10;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_FIND   = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_DUMP   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MISSING = 3'd3,
    ST_TAIL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_APPLY,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    logic                 valid;
    logic [KEY_WIDTH-1:0] key;
  } cell_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] target_key;
    logic        insert_after;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] item_key;
    logic [3:0]  item_position;
    logic [3:0]  entry_count;
    logic        is_empty;
    logic        is_full;
    logic        last;
  } out_t;

endpackage

// ===== hdl/alle_cell.sv =====
module alle_cell import alle_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_op_t             op,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  cell_state_t          left,
  input  cell_state_t          right,
  input  logic [KEY_WIDTH-1:0] cmp_key,
  input  logic                 seen_in,
  output cell_state_t          self_q,
  output logic                 seen_out,
  output logic                 first
);

  logic                 valid_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      unique case (op)
        CELL_HOLD:       valid_r <= valid_r;
        CELL_LOAD:       valid_r <= 1'b1;
        CELL_TAKE_LEFT:  valid_r <= left.valid;
        CELL_TAKE_RIGHT: valid_r <= right.valid;
        CELL_CLEAR:      valid_r <= 1'b0;
        default:         valid_r <= valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_LOAD:       key_r <= new_key;
      CELL_TAKE_LEFT:  key_r <= left.key;
      CELL_TAKE_RIGHT: key_r <= right.key;
      default:         key_r <= key_r;
    endcase
  end

  assign match    = valid_r && (key_r == cmp_key);
  assign first    = match && !seen_in;
  assign seen_out = seen_in || match;
  assign self_q   = '{valid: valid_r, key: key_r};

endmodule

// ===== hdl/array_linked_list_engine.sv =====
// The list is kept in list order in a row of CAPACITY cells; an insert shifts the cells past
// the insertion point one place right and a remove shifts them one place left. Every request
// passes in order through accept (S_IDLE), search (S_SRCH), apply (S_APPLY) and the output
// state S_OUT, where it stays until its last result is taken; a dump returns one result per
// element, one per cycle while the output is taken.
`include "assert_macros.svh"

module array_linked_list_engine import alle_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t state_r, state_nxt;
  in_t    req_r;
  logic [IDX_W-1:0] count_r, count_nxt, idx_r, ptr_r, ptr_nxt, ins_pos;
  logic   hit_r;
  out_t   out_r, out_nxt;
  logic   out_valid_r;

  cell_op_t             ops [CAPACITY];
  cell_state_t          cells [CAPACITY];
  logic [CAPACITY:0]    seen;
  logic [CAPACITY-1:0]  first_v;
  logic [CAPACITY-1:0]  valid_v;
  logic [KEY_WIDTH-1:0] cmp_key;
  logic [IDX_W-1:0]     hit_idx;

  assign cmp_key = (req_r.kind == KIND_INSERT) ? req_r.target_key : req_r.key;
  assign seen[0] = 1'b0;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    cell_state_t lft, rgt;
    if (j == 0) begin : g_l0
      assign lft = '0;
    end else begin : g_l
      assign lft = cells[j-1];
    end
    if (j == CAPACITY - 1) begin : g_rn
      assign rgt = '0;
    end else begin : g_r
      assign rgt = cells[j+1];
    end
    alle_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (ops[j]),
      .new_key  (req_r.key),
      .left     (lft),
      .right    (rgt),
      .cmp_key  (cmp_key),
      .seen_in  (seen[j]),
      .self_q   (cells[j]),
      .seen_out (seen[j+1]),
      .first    (first_v[j])
    );
    assign valid_v[j] = cells[j].valid;
  end

  always_comb begin
    hit_idx = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      hit_idx = hit_idx | (first_v[j] ? IDX_W'(j) : '0);
    end
  end

  always_comb begin
    if (count_r == '0) begin
      ins_pos = '0;
    end else if (hit_r) begin
      ins_pos = req_r.insert_after ? idx_r + 1'b1 : idx_r;
    end else begin
      ins_pos = count_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SRCH;
      S_SRCH:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_OUT;
      S_OUT:   if (out_ready && out_r.last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    count_nxt = count_r;
    for (int j = 0; j < CAPACITY; j++) ops[j] = CELL_HOLD;
    if (state_r == S_APPLY) begin
      priority if (req_r.kind == KIND_INSERT && count_r < IDX_W'(CAPACITY)) begin
        count_nxt = count_r + 1'b1;
        for (int j = 0; j < CAPACITY; j++) begin
          if (IDX_W'(j) == ins_pos) ops[j] = CELL_LOAD;
          else if (IDX_W'(j) > ins_pos) ops[j] = CELL_TAKE_LEFT;
        end
      end else if (req_r.kind == KIND_REMOVE && count_r != '0 && hit_r) begin
        count_nxt = count_r - 1'b1;
        for (int j = 0; j < CAPACITY; j++) begin
          if (IDX_W'(j) >= idx_r) ops[j] = CELL_TAKE_RIGHT;
        end
      end else if (req_r.kind == KIND_CLEAR) begin
        count_nxt = '0;
        for (int j = 0; j < CAPACITY; j++) ops[j] = CELL_CLEAR;
      end else begin
        count_nxt = count_r;
      end
    end
  end

  always_comb begin
    out_nxt = out_r;
    ptr_nxt = ptr_r;
    if (state_r == S_APPLY) begin
      out_nxt             = '0;
      out_nxt.last        = 1'b1;
      out_nxt.entry_count = 4'(count_nxt);
      out_nxt.is_empty    = (count_nxt == '0);
      out_nxt.is_full     = (count_nxt >= IDX_W'(CAPACITY));
      ptr_nxt             = IDX_W'(1);
      unique case (req_r.kind)
        KIND_INSERT: begin
          if (count_r >= IDX_W'(CAPACITY)) out_nxt.status = ST_FULL;
          else if (count_r == '0 || hit_r) out_nxt.status = ST_OK;
          else out_nxt.status = ST_TAIL;
        end
        KIND_REMOVE, KIND_FIND: begin
          if (count_r == '0) out_nxt.status = ST_EMPTY;
          else if (!hit_r) out_nxt.status = ST_MISSING;
          else begin
            out_nxt.status = ST_OK;
            out_nxt.found  = (req_r.kind == KIND_FIND);
          end
        end
        KIND_DUMP: begin
          if (count_r == '0) out_nxt.status = ST_EMPTY;
          else begin
            out_nxt.status        = ST_OK;
            out_nxt.item_key      = 32'(cells[0].key);
            out_nxt.item_position = 4'd1;
            out_nxt.last          = (count_r == IDX_W'(1));
          end
        end
        default: out_nxt.status = ST_OK;
      endcase
    end else if (state_r == S_OUT && out_ready && !out_r.last) begin
      out_nxt.item_key      = 32'(cells[ptr_r].key);
      out_nxt.item_position = 4'(ptr_r + 1'b1);
      out_nxt.last          = (ptr_r + 1'b1 == count_r);
      ptr_nxt               = ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_APPLY) out_valid_r <= 1'b1;
      else if (state_r == S_OUT && out_ready && out_r.last) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) req_r <= in_data;
    if (state_r == S_SRCH) begin
      hit_r <= seen[CAPACITY];
      idx_r <= hit_idx;
    end
    out_r <= out_nxt;
    ptr_r <= ptr_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ALLE_ASSERT(a_count_range, count_r <= IDX_W'(CAPACITY), "element count beyond capacity")
  `ALLE_ASSERT(a_cells_match_count, $countones(valid_v) == int'(count_r), "cells disagree")
  `ALLE_ASSERT(a_out_in_state, out_valid_r |-> state_r == S_OUT, "result shown outside output state")
  `ALLE_ASSERT(a_accept_search, (in_valid && in_ready) |=> state_r == S_SRCH, "request not searched")

endmodule
